>>> rtl/ntc_pkg.sv
// ntc_pkg: shared widths, status codes, word types and log2 table entry function
// for the ntc thermistor read-out; depends on nothing
package ntc_pkg;

	localparam int VIN_W  = 24;
	localparam int UV_W   = 23;
	localparam int NUM_W  = 43;
	localparam int LOG_W  = 36;
	localparam int L2_W   = 38;
	localparam int PROD_W = 62;
	localparam int MAG_W  = 61;
	localparam int INV_W  = 63;
	localparam int RES_W  = 20;
	localparam int TEMP_W = 14;
	localparam int ST_W   = 3;
	localparam int CFG_W  = 20;
	localparam int ADDR_W = 3;

	localparam logic [ST_W-1:0] ST_OK   = 3'd0;
	localparam logic [ST_W-1:0] ST_BUS  = 3'd1;
	localparam logic [ST_W-1:0] ST_NEG  = 3'd2;
	localparam logic [ST_W-1:0] ST_OPEN = 3'd3;
	localparam logic [ST_W-1:0] ST_IMPL = 3'd4;

	localparam logic [ADDR_W-1:0] REG_SUPPLY  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_FIXED   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_BETA    = 3'd2;
	localparam logic [ADDR_W-1:0] REG_NOMINAL = 3'd3;
	localparam logic [ADDR_W-1:0] REG_NOM_CK  = 3'd4;
	localparam logic [ADDR_W-1:0] REG_OFFSET  = 3'd5;

	localparam logic [23:0]      LN2_Q24   = 24'd11629080;
	localparam logic [MAG_W-1:0] SCALE_NUM = MAG_W'(100) << 54;
	localparam logic [RES_W-1:0] RES_MAX   = 20'd1000000;
	localparam logic [18:0]      OPEN_OHM  = 19'd500000;

	typedef struct packed {
		logic [12:0]        supply_mv;
		logic [19:0]        fixed_ohm;
		logic [13:0]        beta_kelvin;
		logic [19:0]        nominal_ohm;
		logic [15:0]        nominal_centikelvin;
		logic signed [13:0] offset_centideg;
	} cfg_t;

	typedef struct packed {
		logic             calc;
		logic [ST_W-1:0]  status;
		logic [NUM_W-1:0] num;
		logic [UV_W-1:0]  uv;
	} front_word_t;

	typedef struct packed {
		logic [TEMP_W-1:0] temperature;
		logic [RES_W-1:0]  resistance;
		logic [ST_W-1:0]   status;
		logic              disconnected;
	} result_word_t;

	// log2(1 + i/2^tb) in q30 by repeated squaring
	function automatic logic [30:0] log_entry(int unsigned tb, int unsigned i);
		logic [63:0] y;
		logic [30:0] acc;
		y = 64'd1073741824 + (64'(i) << (30 - tb));
		acc = '0;
		if (y >= 64'd2147483648) begin
			return 31'd1073741824;
		end
		for (int k = 1; k <= 30; k++) begin
			y = (y * y) >> 30;
			if (y >= 64'd2147483648) begin
				y = y >> 1;
				acc[30-k] = 1'b1;
			end
		end
		return acc;
	endfunction

endpackage

>>> rtl/ntc_thermistor_temperature.sv
// ntc_thermistor_temperature: top level of the ntc thermistor read-out
// depends on ntc_pkg, ntc_fifo, ntc_front, ntc_back
//
// channel   direction  handshake             payload
// sample    in         push / full           voltage_uv
// result    out        pop / empty           temperature_centideg, resistance_ohm,
//                                            status, disconnected
// config    in         cfg_wr (no wait)      cfg_addr, cfg_wdata
//
// one word enters per cycle and one result leaves per cycle when nothing stalls
// each word passes a chain of bit-per-stage dividers
// (43 for resistance, 61 for the beta term, 61 for temperature)
// arst_n clears every valid flag and pointer and loads the register defaults
// a stalled output holds the whole back pipeline; the front then fills its queue
// and raises full
module ntc_thermistor_temperature #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [ntc_pkg::VIN_W-1:0]        voltage_uv,
	output logic                             empty,
	input  logic                             pop,
	output logic [ntc_pkg::TEMP_W-1:0]       temperature_centideg,
	output logic [ntc_pkg::RES_W-1:0]        resistance_ohm,
	output logic [ntc_pkg::ST_W-1:0]         status,
	output logic                             disconnected,
	input  logic                             cfg_wr,
	input  logic [ntc_pkg::ADDR_W-1:0]       cfg_addr,
	input  logic [ntc_pkg::CFG_W-1:0]        cfg_wdata
);
	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	ntc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.supply_mv           <= 13'd3300;
			cfg_q.fixed_ohm           <= 20'd1000;
			cfg_q.beta_kelvin         <= 14'd3950;
			cfg_q.nominal_ohm         <= 20'd10000;
			cfg_q.nominal_centikelvin <= 16'd29815;
			cfg_q.offset_centideg     <= '0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				ntc_pkg::REG_SUPPLY:  cfg_q.supply_mv           <= cfg_wdata[12:0];
				ntc_pkg::REG_FIXED:   cfg_q.fixed_ohm           <= cfg_wdata[19:0];
				ntc_pkg::REG_BETA:    cfg_q.beta_kelvin         <= cfg_wdata[13:0];
				ntc_pkg::REG_NOMINAL: cfg_q.nominal_ohm         <= cfg_wdata[19:0];
				ntc_pkg::REG_NOM_CK:  cfg_q.nominal_centikelvin <= cfg_wdata[15:0];
				ntc_pkg::REG_OFFSET:  cfg_q.offset_centideg     <= $signed(cfg_wdata[13:0]);
				default: ;
			endcase
		end
	end

	// front: range checks and numerator
	logic                 f_push, mid_full, mid_empty, b_pop;
	ntc_pkg::front_word_t f_word, mid_word;

	ntc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .voltage_uv(voltage_uv), .full(full),
		.out_push(f_push), .out_word(f_word), .out_full(mid_full)
	);

	// short queue between front and back
	ntc_fifo #(.WIDTH($bits(ntc_pkg::front_word_t)), .DEPTH(4)) u_mid_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(f_push), .din(f_word), .full(mid_full),
		.pop(b_pop), .dout(mid_word), .empty(mid_empty)
	);

	// back: division, logs, beta equation
	logic                  r_push, out_full;
	ntc_pkg::result_word_t r_word, o_word;

	ntc_back #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(!mid_empty), .in_word(mid_word), .in_pop(b_pop),
		.out_push(r_push), .out_word(r_word), .out_full(out_full)
	);

	// result queue parts the back pipeline from the consumer
	ntc_fifo #(.WIDTH($bits(ntc_pkg::result_word_t)), .DEPTH(2)) u_out_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(r_push), .din(r_word), .full(out_full),
		.pop(pop), .dout(o_word), .empty(empty)
	);

	assign temperature_centideg = o_word.temperature;
	assign resistance_ohm       = o_word.resistance;
	assign status               = o_word.status;
	assign disconnected         = o_word.disconnected;
endmodule

>>> rtl/ntc_fifo.sv
// ntc_fifo: small flop-based first-in first-out queue
// depends on nothing; DEPTH must be a power of two
module ntc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end
endmodule

>>> rtl/ntc_div.sv
// ntc_div: pipelined restoring divider, one quotient bit per stage, with a tag
// depends on nothing
module ntc_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [NW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);
	logic [NW-1:0] nq_q  [NW];
	logic [DW-1:0] rem_q [NW];
	logic [DW-1:0] den_q [NW];
	logic [TW-1:0] tag_q [NW];
	logic          vld_q [NW];

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [NW-1:0] nq_i;
		logic [DW-1:0] rem_i, den_i;
		logic [TW-1:0] tag_i;
		logic          vld_i;
		logic [DW:0]   cat, sub;
		logic          ge;

		if (g == 0) begin : g_first
			assign nq_i  = in_num;
			assign rem_i = '0;
			assign den_i = in_den;
			assign tag_i = in_tag;
			assign vld_i = in_valid;
		end else begin : g_next
			assign nq_i  = nq_q[g-1];
			assign rem_i = rem_q[g-1];
			assign den_i = den_q[g-1];
			assign tag_i = tag_q[g-1];
			assign vld_i = vld_q[g-1];
		end

		assign cat = {rem_i, nq_i[NW-1]};
		assign ge  = (cat >= {1'b0, den_i});
		assign sub = cat - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[g] <= 1'b0;
			else if (en) vld_q[g] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_q[g]  <= {nq_i[NW-2:0], ge};
				rem_q[g] <= ge ? sub[DW-1:0] : cat[DW-1:0];
				den_q[g] <= den_i;
				tag_q[g] <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[NW-1];
	assign out_quo   = nq_q[NW-1];
	assign out_tag   = tag_q[NW-1];
endmodule

>>> rtl/ntc_log2.sv
// ntc_log2: pipelined q30 log2 over several lanes: normalise, table look-up, interpolate
// depends on ntc_pkg
module ntc_log2 #(
	parameter int TBL_BITS = 8,
	parameter int LANES    = 3,
	parameter int TW       = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [TW-1:0]                         in_tag,
	input  logic [LANES-1:0][ntc_pkg::NUM_W-1:0]  in_x,
	output logic                                  out_valid,
	output logic [TW-1:0]                         out_tag,
	output logic [LANES-1:0][ntc_pkg::LOG_W-1:0]  out_log
);
	localparam int XW = ntc_pkg::NUM_W;
	localparam int NS = 6;
	localparam int FW = 30 - TBL_BITS;
	localparam int TE = 2 ** TBL_BITS;
	localparam int PW = 31 + FW;
	localparam int LAT = NS + 3;

	logic [30:0] tbl [TE + 1];
	for (genvar gi = 0; gi <= TE; gi++) begin : g_tbl
		assign tbl[gi] = ntc_pkg::log_entry(TBL_BITS, gi);
	end

	logic          vld_q [LAT];
	logic [TW-1:0] tag_q [LAT];

	for (genvar j = 0; j < LAT; j++) begin : g_ctl
		logic          vld_i;
		logic [TW-1:0] tag_i;
		if (j == 0) begin : g_first
			assign vld_i = in_valid;
			assign tag_i = in_tag;
		end else begin : g_next
			assign vld_i = vld_q[j-1];
			assign tag_i = tag_q[j-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[j] <= 1'b0;
			else if (en) vld_q[j] <= vld_i;
		end
		always_ff @(posedge clk) begin
			if (en) tag_q[j] <= tag_i;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [XW-1:0]     x_q  [NS];
		logic [5:0]        sh_q [NS];
		logic [30:0]       a_q, b_q, a2_q;
		logic [FW-1:0]     rem_q;
		logic [5:0]        e_q, e2_q;
		logic [PW-1:0]     prod_q;
		logic [ntc_pkg::LOG_W-1:0] log_q;
		logic [30:0]       mant;
		logic [TBL_BITS:0] idx;

		// leading-one search: shift by 32, 16, 8, 4, 2, 1
		for (genvar s = 0; s < NS; s++) begin : g_norm
			localparam int K = 32 >> s;
			logic [XW-1:0] xin;
			logic [5:0]    shin;
			if (s == 0) begin : g_first
				assign xin  = in_x[l];
				assign shin = '0;
			end else begin : g_next
				assign xin  = x_q[s-1];
				assign shin = sh_q[s-1];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					if (xin[XW-1 -: K] == '0) begin
						x_q[s]  <= xin << K;
						sh_q[s] <= shin + 6'(K);
					end else begin
						x_q[s]  <= xin;
						sh_q[s] <= shin;
					end
				end
			end
		end

		assign mant = x_q[NS-1][XW-1 -: 31];
		assign idx  = (TBL_BITS + 1)'(mant[29 -: TBL_BITS]);

		always_ff @(posedge clk) begin
			if (en) begin
				a_q    <= tbl[idx];
				b_q    <= tbl[idx + 1'b1];
				rem_q  <= mant[FW-1:0];
				e_q    <= 6'(XW - 1) - sh_q[NS-1];
				prod_q <= PW'(b_q - a_q) * PW'(rem_q);
				a2_q   <= a_q;
				e2_q   <= e_q;
				log_q  <= (ntc_pkg::LOG_W'(e2_q) << 30) + ntc_pkg::LOG_W'(a2_q)
					+ ntc_pkg::LOG_W'(prod_q >> FW);
			end
		end

		assign out_log[l] = log_q;
	end

	assign out_valid = vld_q[LAT-1];
	assign out_tag   = tag_q[LAT-1];
endmodule

>>> rtl/ntc_front.sv
// ntc_front: takes voltage words, range checks them and forms the divider numerator
// depends on ntc_pkg
module ntc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ntc_pkg::cfg_t                  cfg,
	input  logic                           push,
	input  logic [ntc_pkg::VIN_W-1:0]      voltage_uv,
	output logic                           full,
	output logic                           out_push,
	output ntc_pkg::front_word_t           out_word,
	input  logic                           out_full
);
	localparam int UW = ntc_pkg::UV_W;
	localparam int NW = ntc_pkg::NUM_W;

	logic                      en, accept;
	logic [UW-1:0]             vcc_q, short_q;
	logic                      vld_s1, vld_s2, vld_s3;
	logic [ntc_pkg::VIN_W-1:0] v_s1;
	logic [ntc_pkg::ST_W-1:0]  st_s2, st_s3, st_c;
	logic                      calc_s2, calc_s3, calc_c;
	logic [UW-1:0]             uv_s2, diff_s2, uv_s3;
	logic [NW-1:0]             num_s3;
	logic [NW-2:0]             lim_s3;
	logic                      cfg_zero;

	assign en       = !(vld_s3 && out_full);
	assign full     = !en;
	assign accept   = push && en;
	assign cfg_zero = (cfg.nominal_ohm == '0) || (cfg.beta_kelvin == '0)
		|| (cfg.nominal_centikelvin == '0);

	// supply in microvolts and the short threshold
	always_ff @(posedge clk) begin
		vcc_q   <= UW'(cfg.supply_mv) * UW'(1000);
		short_q <= UW'(cfg.supply_mv) * UW'(990);
	end

	always_comb begin
		calc_c = 1'b0;
		st_c   = ntc_pkg::ST_OK;
		if ($signed(v_s1) < -24'sd500000) st_c = ntc_pkg::ST_BUS;
		else if (v_s1[ntc_pkg::VIN_W-1]) st_c = ntc_pkg::ST_NEG;
		else if (v_s1[UW-1:0] < UW'(50000)) st_c = ntc_pkg::ST_OPEN;
		else if (v_s1[UW-1:0] >= short_q) st_c = ntc_pkg::ST_IMPL;
		else calc_c = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1    <= voltage_uv;
			st_s2   <= st_c;
			calc_s2 <= calc_c;
			uv_s2   <= v_s1[UW-1:0];
			diff_s2 <= vcc_q - v_s1[UW-1:0];
			num_s3  <= NW'(cfg.fixed_ohm) * NW'(diff_s2);
			lim_s3  <= (NW - 1)'(ntc_pkg::OPEN_OHM) * (NW - 1)'(uv_s2);
			uv_s3   <= uv_s2;
			st_s3   <= st_s2;
			calc_s3 <= calc_s2;
		end
	end

	always_comb begin
		out_word.calc   = calc_s3;
		out_word.status = st_s3;
		out_word.num    = num_s3;
		out_word.uv     = uv_s3;
		if (calc_s3) begin
			if (num_s3 > NW'(lim_s3)) out_word.status = ntc_pkg::ST_OPEN;
			else if (num_s3 == '0 || cfg_zero) out_word.status = ntc_pkg::ST_IMPL;
		end
	end

	assign out_push = vld_s3 && !out_full;
endmodule

>>> rtl/ntc_back.sv
// ntc_back: resistance quotient, log2 of the ratio, beta equation and final checks
// depends on ntc_pkg, ntc_div, ntc_log2
module ntc_back #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ntc_pkg::cfg_t           cfg,
	input  logic                    in_valid,
	input  ntc_pkg::front_word_t    in_word,
	output logic                    in_pop,
	output logic                    out_push,
	output ntc_pkg::result_word_t   out_word,
	input  logic                    out_full
);
	typedef struct packed {
		logic                       calc;
		logic [ntc_pkg::ST_W-1:0]   status;
		logic [ntc_pkg::RES_W-1:0]  res;
	} carry_t;

	typedef struct packed {
		carry_t c;
		logic   inv_pos;
	} tcarry_t;

	localparam int MW = ntc_pkg::MAG_W;
	localparam int IW = ntc_pkg::INV_W;

	logic en;
	assign en     = !out_full;
	assign in_pop = en && in_valid;

	// resistance quotient
	logic                         rv;
	logic [ntc_pkg::NUM_W-1:0]    rq;
	ntc_pkg::front_word_t         rw;
	carry_t                       rc;

	ntc_div #(.NW(ntc_pkg::NUM_W), .DW(ntc_pkg::UV_W), .TW($bits(ntc_pkg::front_word_t)))
	u_div_res (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.in_num(in_word.num), .in_den(in_word.uv), .in_tag(in_word),
		.out_valid(rv), .out_quo(rq), .out_tag(rw)
	);

	always_comb begin
		rc.calc   = rw.calc;
		rc.status = rw.status;
		if (rw.calc) begin
			rc.res = (rq > ntc_pkg::NUM_W'(ntc_pkg::RES_MAX)) ? ntc_pkg::RES_MAX
				: rq[ntc_pkg::RES_W-1:0];
		end else begin
			rc.res = (rw.status == ntc_pkg::ST_OPEN) ? ntc_pkg::RES_MAX : '0;
		end
	end

	// three logs: numerator, voltage, nominal resistance
	logic                                    lv;
	carry_t                                  lc;
	logic [2:0][ntc_pkg::NUM_W-1:0]          lx;
	logic [2:0][ntc_pkg::LOG_W-1:0]          lg;

	assign lx[0] = rw.num;
	assign lx[1] = ntc_pkg::NUM_W'(rw.uv);
	assign lx[2] = ntc_pkg::NUM_W'(cfg.nominal_ohm);

	ntc_log2 #(.TBL_BITS(LOG_TABLE_BITS), .LANES(3), .TW($bits(carry_t))) u_log (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(rv), .in_tag(rc), .in_x(lx),
		.out_valid(lv), .out_tag(lc), .out_log(lg)
	);

	logic                              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	carry_t                            c_s1, c_s2, c_s3, c_s4, c_s5;
	logic signed [ntc_pkg::L2_W-1:0]   l2_s1;
	logic [42:0]                       plo_s2;
	logic signed [43:0]                phi_s2;
	logic signed [ntc_pkg::PROD_W-1:0] p_s3;
	logic [MW-1:0]                     mag_s4;
	logic                              neg_s4;
	logic signed [IW-1:0]              inv_s5;
	logic                              pos_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= lv;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= lc;
			l2_s1  <= $signed({2'b00, lg[0]}) - $signed({2'b00, lg[1]})
				- $signed({2'b00, lg[2]});
			c_s2   <= c_s1;
			plo_s2 <= 43'(l2_s1[18:0]) * 43'(ntc_pkg::LN2_Q24);
			phi_s2 <= 44'($signed(l2_s1[37:19])) * 44'($signed({1'b0, ntc_pkg::LN2_Q24}));
			c_s3   <= c_s2;
			p_s3   <= (ntc_pkg::PROD_W'(phi_s2) <<< 19) + ntc_pkg::PROD_W'(plo_s2);
			c_s4   <= c_s3;
			neg_s4 <= p_s3[ntc_pkg::PROD_W-1];
			mag_s4 <= p_s3[ntc_pkg::PROD_W-1] ? MW'(-p_s3) : MW'(p_s3);
		end
	end

	// ratio term over beta, and the reference term, side by side
	logic          bv, cv;
	logic          bneg;
	logic [MW-1:0] bq, cq;
	carry_t        cc;

	ntc_div #(.NW(MW), .DW(14), .TW(1)) u_div_beta (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.in_num(mag_s4), .in_den(cfg.beta_kelvin), .in_tag(neg_s4),
		.out_valid(bv), .out_quo(bq), .out_tag(bneg)
	);

	ntc_div #(.NW(MW), .DW(16), .TW($bits(carry_t))) u_div_ref (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s4),
		.in_num(ntc_pkg::SCALE_NUM), .in_den(cfg.nominal_centikelvin), .in_tag(c_s4),
		.out_valid(cv), .out_quo(cq), .out_tag(cc)
	);

	logic signed [IW-1:0] inv_c;
	assign inv_c = bneg ? ($signed(IW'(cq)) - $signed(IW'(bq)))
		: ($signed(IW'(cq)) + $signed(IW'(bq)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= bv && cv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5   <= cc;
			inv_s5 <= inv_c;
			pos_s5 <= !inv_c[IW-1] && (inv_c != '0);
		end
	end

	// temperature in centikelvin
	logic          tv;
	logic [MW-1:0] tq;
	tcarry_t       ti, to;

	assign ti.c       = c_s5;
	assign ti.inv_pos = pos_s5;

	ntc_div #(.NW(MW), .DW(IW - 1), .TW($bits(tcarry_t))) u_div_temp (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s5),
		.in_num(ntc_pkg::SCALE_NUM), .in_den(inv_s5[IW-2:0]), .in_tag(ti),
		.out_valid(tv), .out_quo(tq), .out_tag(to)
	);

	logic signed [IW-1:0]     t;
	logic                     t_bad;
	logic [ntc_pkg::ST_W-1:0] st;

	assign t = $signed({2'b00, tq}) - $signed(IW'(27315)) + IW'(cfg.offset_centideg);
	assign t_bad = t[IW-1] || (t == '0) || ($unsigned(t) > IW'(15000));

	always_comb begin
		st = to.c.status;
		if (to.c.calc && to.c.status == ntc_pkg::ST_OK) begin
			if (!to.inv_pos || t_bad) st = ntc_pkg::ST_IMPL;
		end
		out_word.status       = st;
		out_word.resistance   = to.c.res;
		out_word.disconnected = (st != ntc_pkg::ST_OK);
		out_word.temperature  = (st == ntc_pkg::ST_OK) ? t[ntc_pkg::TEMP_W-1:0] : '0;
	end

	assign out_push = tv && en;
endmodule

>>> rtl/ntc_checker.sv
// ntc_checker: port-level checks on the result side of the read-out
// depends on ntc_pkg; bound to ntc_thermistor_temperature
module ntc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [ntc_pkg::TEMP_W-1:0]  temperature_centideg,
	input logic [ntc_pkg::RES_W-1:0]   resistance_ohm,
	input logic [ntc_pkg::ST_W-1:0]    status,
	input logic                        disconnected
);
	a_disc: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (disconnected == (status != ntc_pkg::ST_OK)))
		else $error("disconnected flag disagrees with status");

	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ntc_pkg::ST_OK) |-> (temperature_centideg == '0))
		else $error("temperature not zero on fault");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ntc_pkg::ST_OK) |->
		(temperature_centideg != '0 && temperature_centideg <= 14'd15000))
		else $error("temperature out of range with ok status");

	a_res_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ntc_pkg::ST_BUS || status == ntc_pkg::ST_NEG))
		|-> (resistance_ohm == '0))
		else $error("resistance not zero on negative input");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(resistance_ohm)))
		else $error("waiting word changed");
endmodule

bind ntc_thermistor_temperature ntc_checker u_checker (.*);
